// ===== hw/rtl/cfrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrq_pkg: shared definitions of the contiguous frame ring queue
// Field widths, command and status codes, default sizes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cfrq_pkg;

    // Payload field widths
    localparam int CMD_W  = 2;
    localparam int LEN_W  = 13;
    localparam int DATA_W = 8;
    localparam int STAT_W = 2;
    localparam int OFF_W  = 12;
    localparam int CNT_W  = 5;
    localparam int TOT_W  = 13;

    // Default sizes
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int FRAME_SLOTS_DEF  = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOROOM = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISUSE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // transaction taken from the request channel
        logic desc_step;  // head descriptor is on the descriptor RAM output
        logic byte_step;  // head byte is on the byte RAM output
        logic next_step;  // next head descriptor is on the descriptor RAM output
        logic finish;     // load the finished read result into the output
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic read_go;    // the offered request is a read that will proceed
        logic need_next;  // the frame just ended and another frame follows
    } dp_status_t;

endpackage

// ===== hw/rtl/cfrq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrq_req_if: request channel
// Valid/ready channel that carries one queue command per transaction.
// ----------------------------------------------------------------------------
interface cfrq_req_if;
    import cfrq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output command, output frame_length,
                    output data_byte, input ready);
    modport sink   (input valid, input command, input frame_length,
                    input data_byte, output ready);
endinterface

// ===== hw/rtl/cfrq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrq_rsp_if: response channel
// Valid/ready channel that carries one command result per transaction.
// ----------------------------------------------------------------------------
interface cfrq_rsp_if;
    import cfrq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  start_offset;
    logic [DATA_W-1:0] read_byte;
    logic              last_of_frame;
    logic [CNT_W-1:0]  frames_queued;
    logic [TOT_W-1:0]  bytes_queued;

    modport source (output valid, output status, output start_offset,
                    output read_byte, output last_of_frame, output frames_queued,
                    output bytes_queued, input ready);
    modport sink   (input valid, input status, input start_offset,
                    input read_byte, input last_of_frame, input frames_queued,
                    input bytes_queued, output ready);
endinterface

// ===== hw/rtl/cfrq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/cfrq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrq_ctrl: queue controller
// Sequences the memory reads of a read command and owns the handshakes.
// ----------------------------------------------------------------------------
module cfrq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  cfrq_pkg::dp_status_t  status,
    output cfrq_pkg::ctrl_cmd_t   cmd
);
    import cfrq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DESC = 5'b00010,
        S_BYTE = 5'b00100,
        S_NEXT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;
    logic   accept;

    // The output register can take a result when it is empty or being emptied.
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    assign cmd.accept    = accept;
    assign cmd.desc_step = (state_reg == S_DESC);
    assign cmd.byte_step = (state_reg == S_BYTE);
    assign cmd.next_step = (state_reg == S_NEXT);
    assign cmd.finish    = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && status.read_go)
                begin
                    state_next = S_DESC;
                end
            end
            S_DESC: state_next = S_BYTE;
            S_BYTE: state_next = status.need_next ? S_NEXT : S_DONE;
            S_NEXT: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if ((accept && !status.read_go) || cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end
endmodule

// ===== hw/rtl/cfrq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrq_dp: queue datapath
// Byte store, descriptor ring, positions, counters and the result register.
// ----------------------------------------------------------------------------
module cfrq_dp #(
    parameter int BUFFER_BYTES = cfrq_pkg::BUFFER_BYTES_DEF,
    parameter int FRAME_SLOTS  = cfrq_pkg::FRAME_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfrq_pkg::ctrl_cmd_t           cmd,
    output cfrq_pkg::dp_status_t          status,
    input  logic [cfrq_pkg::CMD_W-1:0]    command,
    input  logic [cfrq_pkg::LEN_W-1:0]    frame_length,
    input  logic [cfrq_pkg::DATA_W-1:0]   data_byte,
    output logic [cfrq_pkg::STAT_W-1:0]   status_out,
    output logic [cfrq_pkg::OFF_W-1:0]    start_offset,
    output logic [cfrq_pkg::DATA_W-1:0]   read_byte,
    output logic                          last_of_frame,
    output logic [cfrq_pkg::CNT_W-1:0]    frames_queued,
    output logic [cfrq_pkg::TOT_W-1:0]    bytes_queued
);
    import cfrq_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int LW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = $clog2(FRAME_SLOTS);
    localparam int CW = $clog2(FRAME_SLOTS + 1);
    localparam int DW = AW + LW;

    localparam logic [LW-1:0] BUF_L     = LW'(BUFFER_BYTES);
    localparam logic [AW:0]   BUF_S     = (AW + 1)'(BUFFER_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(FRAME_SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C   = CW'(FRAME_SLOTS);

    // Control state
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] frames_reg, frames_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [LW-1:0] bytes_reg, bytes_next;
    logic [AW-1:0] fill_pos_reg, fill_pos_next;
    logic [LW-1:0] fill_rem_reg, fill_rem_next;
    logic [AW-1:0] drain_reg, drain_next;

    // Payload holding registers
    logic [LW-1:0]     head_len_reg, head_len_next;
    logic [DATA_W-1:0] res_byte_reg, res_byte_next;
    logic              res_last_reg, res_last_next;
    logic [STAT_W-1:0] status_out_reg;
    logic [OFF_W-1:0]  start_offset_reg;
    logic [DATA_W-1:0] read_byte_reg;
    logic              last_of_frame_reg;
    logic [CNT_W-1:0]  frames_queued_reg;
    logic [TOT_W-1:0]  bytes_queued_reg;

    // Memory ports
    logic          byte_we;
    logic [AW-1:0] byte_raddr;
    logic [7:0]    byte_q;
    logic          desc_we;
    logic [SW-1:0] desc_raddr;
    logic [DW-1:0] desc_q;
    logic [AW-1:0] desc_start;
    logic [LW-1:0] desc_len;

    // Reserve placement
    logic [31:0]       len32;
    logic [LW-1:0]     len_l;
    logic              len_bad;
    logic              filling;
    logic [LW-1:0]     rp_l;
    logic [LW-1:0]     wp_l;
    logic [LW-1:0]     gap;
    logic [LW-1:0]     tail_room;
    logic              found;
    logic [AW-1:0]     rsv_start;
    logic [LW-1:0]     end_l;
    logic [AW-1:0]     wp_after;
    logic [STAT_W-1:0] rsv_status;
    logic              rsv_ok;

    // Read path
    logic [STAT_W-1:0] rd_status;
    logic              read_go;
    logic [SW-1:0]     next_head;
    logic [SW-1:0]     next_tail;
    logic [AW:0]       addr_sum;
    logic [AW:0]       addr_wrap;
    logic [LW-1:0]     drain_inc;
    logic              last;
    logic [CW-1:0]     frames_dec;
    logic [LW-1:0]     byte_sub;

    // Result
    logic              out_load;
    logic [STAT_W-1:0] cmd_status;

    assign len32   = 32'(frame_length);
    assign len_l   = LW'(frame_length);
    assign len_bad = (frame_length == '0) || (len32 > 32'(BUFFER_BYTES));
    assign filling = (fill_rem_reg != '0);

    assign rp_l      = LW'(rp_reg);
    assign wp_l      = LW'(wp_reg);
    assign gap       = rp_l - wp_l;
    assign tail_room = BUF_L - wp_l;

    // An empty queue starts over at offset zero; otherwise the frame goes in
    // the gap before the read position, in the tail space, or wrapped to zero.
    always_comb
    begin
        found     = 1'b0;
        rsv_start = '0;
        if (frames_reg == '0)
        begin
            found = 1'b1;
        end
        else if (wp_reg < rp_reg)
        begin
            if (len_l <= gap)
            begin
                found     = 1'b1;
                rsv_start = wp_reg;
            end
        end
        else if (wp_reg > rp_reg)
        begin
            if (len_l <= tail_room)
            begin
                found     = 1'b1;
                rsv_start = wp_reg;
            end
            else if (len_l <= rp_l)
            begin
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (filling)
        begin
            rsv_status = ST_MISUSE;
        end
        else if (len_bad || (frames_reg >= SLOTS_C) || !found)
        begin
            rsv_status = ST_NOROOM;
        end
        else
        begin
            rsv_status = ST_OK;
        end
    end

    assign rsv_ok   = (rsv_status == ST_OK);
    assign end_l    = LW'(rsv_start) + len_l;
    assign wp_after = (end_l >= BUF_L) ? '0 : end_l[AW-1:0];

    // The head frame may be read unless it is the one still being filled.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            rd_status = ST_EMPTY;
        end
        else if (filling && (frames_reg == CW'(1)))
        begin
            rd_status = ST_MISUSE;
        end
        else
        begin
            rd_status = ST_OK;
        end
    end

    assign read_go          = (command == CMD_READ) && (rd_status == ST_OK);
    assign status.read_go   = read_go;

    assign next_head = (head_reg == LAST_SLOT) ? '0 : head_reg + SW'(1);
    assign next_tail = (tail_reg == LAST_SLOT) ? '0 : tail_reg + SW'(1);

    // Descriptor ring
    assign desc_we    = cmd.accept && (command == CMD_RESERVE) && rsv_ok;
    assign desc_raddr = cmd.byte_step ? next_head : head_reg;
    assign desc_start = desc_q[DW-1:LW];
    assign desc_len   = desc_q[LW-1:0];

    cfrq_ram #(
        .WIDTH (DW),
        .DEPTH (FRAME_SLOTS)
    ) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (tail_reg),
        .wdata ({rsv_start, len_l}),
        .raddr (desc_raddr),
        .rdata (desc_q)
    );

    // Byte store, read at frame start plus bytes already drained
    assign addr_sum   = {1'b0, desc_start} + {1'b0, drain_reg};
    assign addr_wrap  = addr_sum - BUF_S;
    assign byte_raddr = (addr_sum >= BUF_S) ? addr_wrap[AW-1:0] : addr_sum[AW-1:0];
    assign byte_we    = cmd.accept && (command == CMD_WRITE) && filling;

    cfrq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_BYTES)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (fill_pos_reg),
        .wdata (data_byte),
        .raddr (byte_raddr),
        .rdata (byte_q)
    );

    assign drain_inc        = LW'(drain_reg) + LW'(1);
    assign last             = (drain_inc >= head_len_reg);
    assign frames_dec       = frames_reg - CW'(1);
    assign byte_sub         = (head_len_reg <= bytes_reg) ? head_len_reg : bytes_reg;
    assign status.need_next = last && (frames_dec != '0);

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        frames_next   = frames_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        bytes_next    = bytes_reg;
        fill_pos_next = fill_pos_reg;
        fill_rem_next = fill_rem_reg;
        drain_next    = drain_reg;
        head_len_next = head_len_reg;
        res_byte_next = res_byte_reg;
        res_last_next = res_last_reg;

        if (cmd.accept)
        begin
            case (command)
                CMD_RESERVE:
                begin
                    if (rsv_ok)
                    begin
                        tail_next     = next_tail;
                        frames_next   = frames_reg + CW'(1);
                        bytes_next    = bytes_reg + len_l;
                        wp_next       = wp_after;
                        fill_pos_next = rsv_start;
                        fill_rem_next = len_l;
                        if (frames_reg == '0)
                        begin
                            rp_next = '0;
                        end
                    end
                end
                CMD_WRITE:
                begin
                    if (filling)
                    begin
                        fill_pos_next = (fill_pos_reg == LAST_ADDR) ? '0
                                                                    : fill_pos_reg + AW'(1);
                        fill_rem_next = fill_rem_reg - LW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.desc_step)
        begin
            head_len_next = desc_len;
        end

        if (cmd.byte_step)
        begin
            res_byte_next = byte_q;
            res_last_next = last;
            if (last)
            begin
                drain_next  = '0;
                bytes_next  = bytes_reg - byte_sub;
                head_next   = next_head;
                frames_next = frames_dec;
                if (frames_dec == '0)
                begin
                    rp_next = '0;
                    wp_next = '0;
                end
            end
            else
            begin
                drain_next = drain_inc[AW-1:0];
            end
        end

        // Once the head has moved on, the read position follows its frame.
        if (cmd.next_step)
        begin
            rp_next = desc_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            frames_reg   <= '0;
            rp_reg       <= '0;
            wp_reg       <= '0;
            bytes_reg    <= '0;
            fill_pos_reg <= '0;
            fill_rem_reg <= '0;
            drain_reg    <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            frames_reg   <= frames_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            bytes_reg    <= bytes_next;
            fill_pos_reg <= fill_pos_next;
            fill_rem_reg <= fill_rem_next;
            drain_reg    <= drain_next;
        end
    end

    // Status of a command that completes in its acceptance cycle.
    always_comb
    begin
        case (command)
            CMD_RESERVE: cmd_status = rsv_status;
            CMD_WRITE:   cmd_status = filling ? ST_OK : ST_MISUSE;
            CMD_READ:    cmd_status = rd_status;
            default:     cmd_status = ST_MISUSE;
        endcase
    end

    assign out_load = (cmd.accept && !read_go) || cmd.finish;

    always_ff @(posedge clk)
    begin
        head_len_reg <= head_len_next;
        res_byte_reg <= res_byte_next;
        res_last_reg <= res_last_next;
        if (out_load)
        begin
            if (cmd.finish)
            begin
                status_out_reg    <= ST_OK;
                start_offset_reg  <= '0;
                read_byte_reg     <= res_byte_reg;
                last_of_frame_reg <= res_last_reg;
            end
            else
            begin
                status_out_reg    <= cmd_status;
                start_offset_reg  <= ((command == CMD_RESERVE) && rsv_ok) ? OFF_W'(rsv_start)
                                                                          : '0;
                read_byte_reg     <= '0;
                last_of_frame_reg <= 1'b0;
            end
            frames_queued_reg <= CNT_W'(frames_next);
            bytes_queued_reg  <= TOT_W'(bytes_next);
        end
    end

    assign status_out    = status_out_reg;
    assign start_offset  = start_offset_reg;
    assign read_byte     = read_byte_reg;
    assign last_of_frame = last_of_frame_reg;
    assign frames_queued = frames_queued_reg;
    assign bytes_queued  = bytes_queued_reg;
endmodule

// ===== hw/rtl/contiguous_frame_ring_queue.sv =====
`timescale 1ns / 1ps
// Reserve, write and rejected commands give their result in the cycle after acceptance.
// A read reads the head descriptor, then the head byte, then the next descriptor when it frees
// a frame and another frame follows, and waits until the output register is free to load it.
// One non-read transaction per cycle while the output register is free; a read holds the block.
// Reset clears pointers and counters at once; the byte and descriptor RAMs are not cleared.
// ----------------------------------------------------------------------------
// contiguous_frame_ring_queue: frame queue over a circular byte store
// Keeps variable-length frames contiguous in a byte RAM, ordered by a ring of
// descriptors, and serves reserve, write-byte and read-byte commands.
// ----------------------------------------------------------------------------
module contiguous_frame_ring_queue #(
    parameter int BUFFER_BYTES = cfrq_pkg::BUFFER_BYTES_DEF,
    parameter int FRAME_SLOTS  = cfrq_pkg::FRAME_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cfrq_req_if.sink    req,
    cfrq_rsp_if.source  rsp
);
    import cfrq_pkg::*;

    // The controller sequences the reads of a read command through the
    // descriptor RAM and the byte RAM, and owns both handshakes. Every other
    // command, and a refused read, finishes in the cycle it is accepted.
    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    cfrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (dp_status),
        .cmd       (cmd)
    );

    // The datapath holds the store, the descriptor ring, the read, write and
    // fill positions, the frame and byte counts, and the result register that
    // parts the request side from the response side.
    cfrq_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .FRAME_SLOTS  (FRAME_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (dp_status),
        .command       (req.command),
        .frame_length  (req.frame_length),
        .data_byte     (req.data_byte),
        .status_out    (rsp.status),
        .start_offset  (rsp.start_offset),
        .read_byte     (rsp.read_byte),
        .last_of_frame (rsp.last_of_frame),
        .frames_queued (rsp.frames_queued),
        .bytes_queued  (rsp.bytes_queued)
    );
endmodule

// ===== tb/tb_contiguous_frame_ring_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_frame_ring_queue: self-checking bench for the frame ring queue
// A directed run first goes through the corner cases: empty reads, misuse,
// bad lengths, full descriptors, reuse of freed descriptors and a frame too
// long for both the tail space and the space before the read position.
// Random command streams follow, shaped as reserve-then-fill frames mixed
// with reads. Every response transaction is compared field by field with an
// in-bench prediction of the queue, or with hand-typed values where a row pins them.
// ----------------------------------------------------------------------------
module tb_contiguous_frame_ring_queue;
    import cfrq_pkg::*;

    // The package has no name for the fourth command code; the block must
    // treat it as misuse.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int BUF_BYTES   = BUFFER_BYTES_DEF;
    localparam int SLOT_COUNT  = FRAME_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 700;
    // Cycles without any transaction on either channel before the run is
    // declared hung. The longest legal quiet stretch is a sender gap, a read
    // and a receiver stall together, far below this.
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTED = 100;

    // One response transaction as the block should produce it.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  start_offset;
        logic [DATA_W-1:0] read_byte;
        logic              last_of_frame;
        logic [CNT_W-1:0]  frames_queued;
        logic [TOT_W-1:0]  bytes_queued;
    } queue_result_t;

    // One row of the directed plan. A row repeats its command reps times;
    // a reserve row with fill set is followed by one data byte per reserved
    // byte. Where pinned is set, status and the two totals are fixed by hand
    // instead of being taken from the prediction.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data;
        logic [12:0]       reps;
        logic              fill;
        logic              pinned;
        logic [STAT_W-1:0] st;
        logic [CNT_W-1:0]  frames;
        logic [TOT_W-1:0]  bytes;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cfrq_req_if req_ch ();
    cfrq_rsp_if rsp_ch ();

    contiguous_frame_ring_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Directed plan. The comments give the queue layout each row leads to.
    // ------------------------------------------------------------------------
    stim_row_t directed_plan [19] = '{
        // Fresh queue: empty read, stray data byte, unknown command.
        '{CMD_READ,    13'd0,    8'h00, 13'd1,    1'b0, 1'b1, ST_EMPTY,  5'd0,  13'd0},
        '{CMD_WRITE,   13'd0,    8'hFF, 13'd1,    1'b0, 1'b1, ST_MISUSE, 5'd0,  13'd0},
        '{CMD_UNUSED,  13'd0,    8'h00, 13'd1,    1'b0, 1'b1, ST_MISUSE, 5'd0,  13'd0},
        // Bad lengths: zero, one past the store, and every length bit set.
        '{CMD_RESERVE, 13'd0,    8'h00, 13'd1,    1'b0, 1'b1, ST_NOROOM, 5'd0,  13'd0},
        '{CMD_RESERVE, 13'd4097, 8'h00, 13'd1,    1'b0, 1'b1, ST_NOROOM, 5'd0,  13'd0},
        '{CMD_RESERVE, 13'd8191, 8'h00, 13'd1,    1'b0, 1'b1, ST_NOROOM, 5'd0,  13'd0},
        // A single frame of eight bytes. While it is being filled a read and
        // a second reserve are both misuse.
        '{CMD_RESERVE, 13'd8,    8'h00, 13'd1,    1'b0, 1'b1, ST_OK,     5'd1,  13'd8},
        '{CMD_READ,    13'd0,    8'h00, 13'd1,    1'b0, 1'b1, ST_MISUSE, 5'd1,  13'd8},
        '{CMD_RESERVE, 13'd1,    8'h00, 13'd1,    1'b0, 1'b1, ST_MISUSE, 5'd1,  13'd8},
        '{CMD_WRITE,   13'd0,    8'h00, 13'd8,    1'b0, 1'b0, ST_OK,     5'd0,  13'd0},
        // The frame is complete, so a data byte is misuse.
        '{CMD_WRITE,   13'd0,    8'h3C, 13'd1,    1'b0, 1'b1, ST_MISUSE, 5'd1,  13'd8},
        '{CMD_READ,    13'd0,    8'h00, 13'd8,    1'b0, 1'b0, ST_OK,     5'd0,  13'd0},
        '{CMD_READ,    13'd0,    8'h00, 13'd1,    1'b0, 1'b1, ST_EMPTY,  5'd0,  13'd0},
        // Sixteen frames of 2 bytes use every descriptor; plenty of store
        // space stays free but no descriptor does.
        '{CMD_RESERVE, 13'd2,    8'h5A, 13'd16,   1'b1, 1'b0, ST_OK,     5'd0,  13'd0},
        '{CMD_RESERVE, 13'd1,    8'h00, 13'd1,    1'b0, 1'b1, ST_NOROOM, 5'd16, 13'd32},
        // Free three frames: read position 6, write position 32.
        '{CMD_READ,    13'd0,    8'h00, 13'd6,    1'b0, 1'b0, ST_OK,     5'd0,  13'd0},
        // A freed descriptor takes a frame at the write position, up to 52.
        '{CMD_RESERVE, 13'd20,   8'hC3, 13'd1,    1'b1, 1'b0, ST_OK,     5'd0,  13'd0},
        // Too long for the tail space and for the space before position 6.
        '{CMD_RESERVE, 13'd4090, 8'h00, 13'd1,    1'b0, 1'b1, ST_NOROOM, 5'd14, 13'd46},
        // Drain all 46 bytes and read once more from the empty queue.
        '{CMD_READ,    13'd0,    8'h00, 13'd47,   1'b0, 1'b0, ST_OK,     5'd0,  13'd0}
    };

    // ------------------------------------------------------------------------
    // Predicted queue contents.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] store_image [BUF_BYTES];
    int desc_start [SLOT_COUNT];
    int desc_len   [SLOT_COUNT];
    int head_idx    = 0;
    int tail_idx    = 0;
    int held_frames = 0;
    int held_bytes  = 0;
    int rd_ptr      = 0;
    int wr_ptr      = 0;
    int fill_ptr    = 0;
    int fill_left   = 0;    // zero when no frame is waiting for data bytes
    int drained     = 0;    // bytes already read from the head frame

    queue_result_t results_due [$];
    int error_count  = 0;
    int result_count = 0;
    int burst_left   = 0;

    // Applies one accepted command to the predicted queue and returns the
    // response it must produce.
    function automatic queue_result_t predict_queue_step(input logic [CMD_W-1:0] cmd,
                                                         input int len,
                                                         input logic [DATA_W-1:0] data);
        queue_result_t r;
        int start;
        bit placed;

        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_RESERVE:
            begin
                if (fill_left != 0)
                begin
                    r.status = ST_MISUSE;
                end
                else if (len == 0 || len > BUF_BYTES || held_frames >= SLOT_COUNT)
                begin
                    r.status = ST_NOROOM;
                end
                else
                begin
                    start  = 0;
                    placed = 1'b0;
                    if (held_frames == 0)
                    begin
                        // An empty queue always starts over at offset zero.
                        rd_ptr = 0;
                        wr_ptr = 0;
                        placed = 1'b1;
                    end
                    else if (wr_ptr < rd_ptr)
                    begin
                        if (len <= rd_ptr - wr_ptr)
                        begin
                            start  = wr_ptr;
                            placed = 1'b1;
                        end
                    end
                    else if (wr_ptr > rd_ptr)
                    begin
                        if (len <= BUF_BYTES - wr_ptr)
                        begin
                            start  = wr_ptr;
                            placed = 1'b1;
                        end
                        else if (len <= rd_ptr)
                        begin
                            placed = 1'b1;
                        end
                    end
                    if (!placed || start + len > BUF_BYTES)
                    begin
                        r.status = ST_NOROOM;
                    end
                    else
                    begin
                        desc_start[tail_idx] = start;
                        desc_len[tail_idx]   = len;
                        tail_idx    = (tail_idx + 1) % SLOT_COUNT;
                        held_frames = held_frames + 1;
                        held_bytes  = held_bytes + len;
                        wr_ptr      = (start + len >= BUF_BYTES) ? 0 : start + len;
                        fill_ptr    = start;
                        fill_left   = len;
                        r.start_offset = OFF_W'(start);
                    end
                end
            end
            CMD_WRITE:
            begin
                if (fill_left == 0)
                begin
                    r.status = ST_MISUSE;
                end
                else
                begin
                    store_image[fill_ptr] = data;
                    fill_ptr  = (fill_ptr + 1) % BUF_BYTES;
                    fill_left = fill_left - 1;
                end
            end
            CMD_READ:
            begin
                if (held_frames == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (fill_left != 0 && held_frames == 1)
                begin
                    r.status = ST_MISUSE;
                end
                else
                begin
                    r.read_byte = store_image[(desc_start[head_idx] + drained) % BUF_BYTES];
                    drained = drained + 1;
                    if (drained >= desc_len[head_idx])
                    begin
                        r.last_of_frame = 1'b1;
                        drained     = 0;
                        held_bytes  = held_bytes - desc_len[head_idx];
                        head_idx    = (head_idx + 1) % SLOT_COUNT;
                        held_frames = held_frames - 1;
                        if (held_frames == 0)
                        begin
                            rd_ptr = 0;
                            wr_ptr = 0;
                        end
                        else
                        begin
                            rd_ptr = desc_start[head_idx];
                        end
                    end
                end
            end
            default:
            begin
                r.status = ST_MISUSE;
            end
        endcase
        r.frames_queued = CNT_W'(held_frames);
        r.bytes_queued  = TOT_W'(held_bytes);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count = error_count + 1;
        if (error_count <= MAX_PRINTED)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                      result_count, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side. The sender offers commands in bursts of random length
    // separated by random gaps; a burst may run straight into the next one.
    // The prediction is taken at the clock edge where the transaction is
    // accepted, so random commands chosen afterwards see up-to-date state.
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [CMD_W-1:0] cmd, input int len, input int data,
                                input bit pinned, input logic [STAT_W-1:0] st,
                                input int frames, input int bytes,
                                output logic [STAT_W-1:0] got_status);
        int gap;
        queue_result_t r;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;

        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.frame_length <= LEN_W'(len);
        req_ch.data_byte    <= DATA_W'(data);
        do
            @(posedge clk);
        while (!req_ch.ready);

        r = predict_queue_step(cmd, len, DATA_W'(data));
        if (pinned)
        begin
            // Hand-typed values take the place of the predicted ones so that
            // the corner rows do not rest on the prediction alone.
            r.status        = st;
            r.frames_queued = CNT_W'(frames);
            r.bytes_queued  = TOT_W'(bytes);
        end
        results_due.push_back(r);
        got_status = r.status;
    endtask

    // Holds the request channel idle until every outstanding response has
    // been collected.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    // Chooses the next random command from the predicted state. While a
    // frame is open most commands are its data bytes; otherwise the mix
    // leans toward reserves in a growing phase and toward reads in a
    // draining phase, so that the descriptor ring both fills and empties.
    task automatic pick_random_command(input bit growing, output logic [CMD_W-1:0] cmd,
                                       output int len, output int data);
        int dice;
        int sel;
        int reserve_share;

        dice = $urandom_range(0, 99);
        data = $urandom_range(0, 255);
        len  = 0;
        if (fill_left != 0)
        begin
            if (dice < 88)
                cmd = CMD_WRITE;
            else if (dice < 93)
                cmd = CMD_READ;
            else if (dice < 97)
                cmd = CMD_RESERVE;
            else
                cmd = CMD_UNUSED;
        end
        else
        begin
            reserve_share = growing ? 55 : 15;
            if (dice < reserve_share)
                cmd = CMD_RESERVE;
            else if (dice < 95)
                cmd = CMD_READ;
            else if (dice < 98)
                cmd = CMD_WRITE;
            else
                cmd = CMD_UNUSED;
        end
        if (cmd == CMD_RESERVE)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
                len = $urandom_range(1, 24);
            else if (sel < 94)
                len = $urandom_range(25, 400);
            else if (sel < 97)
                len = 0;
            else
                len = $urandom_range(BUF_BYTES + 1, (1 << LEN_W) - 1);
        end
    endtask

    initial
    begin
        logic [CMD_W-1:0]  cmd;
        logic [STAT_W-1:0] got;
        int len;
        int data;
        int counted;
        int phase_left;
        bit growing;
        stim_row_t row;

        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_READ;
        req_ch.frame_length = '0;
        req_ch.data_byte    = '0;
        foreach (store_image[i])
            store_image[i] = '0;
        foreach (desc_start[i])
        begin
            desc_start[i] = 0;
            desc_len[i]   = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases.
        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            for (int rep = 0; rep < row.reps; rep++)
            begin
                send_command(row.cmd, row.length, row.data + rep, row.pinned, row.st,
                             row.frames, row.bytes, got);
                if (row.fill)
                begin
                    for (int k = 0; k < row.length; k++)
                    begin
                        send_command(CMD_WRITE, 0, row.data + rep * 31 + k, 1'b0,
                                     ST_OK, 0, 0, got);
                    end
                end
            end
        end

        // Random frame traffic. Misuse transactions change nothing in the
        // queue and so are not counted toward the length of the run.
        counted    = 0;
        phase_left = 0;
        growing    = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                growing    = !growing;
                phase_left = $urandom_range(30, 150);
            end
            phase_left = phase_left - 1;
            pick_random_command(growing, cmd, len, data);
            send_command(cmd, len, data, 1'b0, ST_OK, 0, 0, got);
            if (got != ST_MISUSE)
            begin
                counted = counted + 1;
                // Now and then the sender stops until the block has answered
                // everything, so the queue also restarts from a quiet state.
                if (counted % 300 == 0)
                    wait_for_results();
            end
        end

        // Collect the remaining responses, then leave room for a stray one.
        wait_for_results();
        repeat (16) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_contiguous_frame_ring_queue: PASS");
        end
        else
        begin
            $display("tb_contiguous_frame_ring_queue: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side. The receiver changes its behavior every so often:
    // always ready, ready at random, or ready with occasional long stalls.
    // ------------------------------------------------------------------------
    int sink_mode  = 0;
    int mode_left  = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        queue_result_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                          result_count));
            end
            else
            begin
                want = results_due.pop_front();
                check_field("status", rsp_ch.status, want.status);
                check_field("start_offset", rsp_ch.start_offset, want.start_offset);
                check_field("read_byte", rsp_ch.read_byte, want.read_byte);
                check_field("last_of_frame", rsp_ch.last_of_frame, want.last_of_frame);
                check_field("frames_queued", rsp_ch.frames_queued, want.frames_queued);
                check_field("bytes_queued", rsp_ch.bytes_queued, want.bytes_queued);
            end
            result_count = result_count + 1;
        end

        if (mode_left == 0)
        begin
            sink_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 160);
        end
        mode_left = mode_left - 1;
        case (sink_mode)
            0:
            begin
                rsp_ch.ready <= 1'b1;
            end
            1:
            begin
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default:
            begin
                if (stall_left > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    stall_left = stall_left - 1;
                end
                else
                begin
                    rsp_ch.ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                        stall_left = $urandom_range(1, 30);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: the run is hung when neither channel has moved a transaction
    // before the quiet count reaches STALL_LIMIT.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles, %0d responses outstanding",
                         $time, STALL_LIMIT, results_due.size());
                $display("tb_contiguous_frame_ring_queue: FAIL");
                $finish;
            end
        end
    end

endmodule
